// ----- hw/rtl/sha1md_pkg.sv -----
`default_nettype none
package sha1md_pkg;

	localparam logic [31:0] H0 = 32'h67452301;
	localparam logic [31:0] H1 = 32'hEFCDAB89;
	localparam logic [31:0] H2 = 32'h98BADCFE;
	localparam logic [31:0] H3 = 32'h10325476;
	localparam logic [31:0] H4 = 32'hC3D2E1F0;

	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;

	localparam logic [7:0] PAD_BYTE = 8'h80;

	localparam int unsigned ROUNDS = 80;
	localparam int unsigned DIGEST_WORDS = 5;
	localparam logic [6:0] LAST_ROUND = 7'(ROUNDS - 1);
	localparam logic [2:0] LAST_WORD_IDX = 3'(DIGEST_WORDS - 1);
	// block position where the 64-bit length field starts
	localparam logic [5:0] LEN_POS = 6'd56;
	localparam logic [5:0] BLOCK_END = 6'd63;
	localparam logic [2:0] LEN_LAST = 3'd7;

	typedef enum logic [1:0] {
		BSEL_DATA,
		BSEL_PAD,
		BSEL_ZERO,
		BSEL_LEN
	} byte_sel_t;

	typedef struct packed {
		logic       shift_en;
		byte_sel_t  byte_sel;
		logic       total_inc;
		logic       len_load;
		logic       round_en;
		logic [6:0] round_idx;
		logic       chain_add;
		logic       emit_load;
		logic [2:0] emit_idx;
	} cmd_t;

	typedef struct packed {
		logic fill_full;
		logic fill_at_len;
	} status_t;

	function automatic logic [31:0] init_word(input logic [2:0] idx);
		logic [31:0] w;
		unique case (idx)
			3'd0: w = H0;
			3'd1: w = H1;
			3'd2: w = H2;
			3'd3: w = H3;
			3'd4: w = H4;
			default: w = H0;
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/sha1md_dp.sv -----
`default_nettype none
module sha1md_dp
	import sha1md_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cmd_t        cmd,
	input  wire logic [7:0]  data_byte,
	output status_t          st,
	output logic      [31:0] digest
);

	// 16-word window: byte packer while filling, message schedule while hashing
	logic [511:0] win_q;
	logic [5:0]   fill_q;
	logic [60:0]  total_q;
	logic [63:0]  len_q;
	logic [31:0]  chain_q [DIGEST_WORDS];
	logic [31:0]  a_q, b_q, c_q, d_q, e_q;
	logic [31:0]  digest_q;

	logic [7:0]  byte_in;
	logic [31:0] w0, w2, w8, w13, sx, w_new;
	logic [31:0] a_c, b_c, c_c, d_c, e_c;
	logic [31:0] f, k, t;
	logic        first;

	always_comb begin
		unique case (cmd.byte_sel)
			BSEL_DATA: byte_in = data_byte;
			BSEL_PAD:  byte_in = PAD_BYTE;
			BSEL_ZERO: byte_in = 8'h00;
			BSEL_LEN:  byte_in = len_q[63:56];
			default:   byte_in = 8'h00;
		endcase
	end

	assign w0    = win_q[511:480];
	assign w2    = win_q[447:416];
	assign w8    = win_q[255:224];
	assign w13   = win_q[95:64];
	assign sx    = w13 ^ w8 ^ w2 ^ w0;
	assign w_new = {sx[30:0], sx[31]};

	assign first = (cmd.round_idx == 7'd0);
	assign a_c = first ? chain_q[0] : a_q;
	assign b_c = first ? chain_q[1] : b_q;
	assign c_c = first ? chain_q[2] : c_q;
	assign d_c = first ? chain_q[3] : d_q;
	assign e_c = first ? chain_q[4] : e_q;

	always_comb begin
		priority if (cmd.round_idx < 7'd20) begin
			f = (b_c & c_c) | (~b_c & d_c);
			k = K0;
		end else if (cmd.round_idx < 7'd40) begin
			f = b_c ^ c_c ^ d_c;
			k = K1;
		end else if (cmd.round_idx < 7'd60) begin
			f = (b_c & c_c) | (b_c & d_c) | (c_c & d_c);
			k = K2;
		end else begin
			f = b_c ^ c_c ^ d_c;
			k = K3;
		end
	end

	assign t = {a_c[26:0], a_c[31:27]} + f + e_c + k + w0;

	always_ff @(posedge clk) begin
		if (cmd.shift_en) begin
			win_q <= {win_q[503:0], byte_in};
		end else if (cmd.round_en) begin
			win_q <= {win_q[479:0], w_new};
		end
		if (cmd.len_load) begin
			len_q <= {total_q, 3'b000};
		end else if (cmd.shift_en && cmd.byte_sel == BSEL_LEN) begin
			len_q <= {len_q[55:0], 8'h00};
		end
		if (cmd.round_en) begin
			a_q <= t;
			b_q <= a_c;
			c_q <= {b_c[1:0], b_c[31:2]};
			d_q <= c_c;
			e_q <= d_c;
		end
		if (cmd.emit_load) begin
			digest_q <= chain_q[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			total_q <= '0;
			for (int i = 0; i < DIGEST_WORDS; i++) begin
				chain_q[i] <= init_word(3'(i));
			end
		end else begin
			if (cmd.shift_en) begin
				fill_q <= fill_q + 6'd1;
			end
			if (cmd.len_load) begin
				total_q <= '0;
			end else if (cmd.total_inc) begin
				total_q <= total_q + 61'd1;
			end
			if (cmd.chain_add) begin
				chain_q[0] <= chain_q[0] + a_q;
				chain_q[1] <= chain_q[1] + b_q;
				chain_q[2] <= chain_q[2] + c_q;
				chain_q[3] <= chain_q[3] + d_q;
				chain_q[4] <= chain_q[4] + e_q;
			end else if (cmd.emit_load) begin
				// rotate words out, refill the tail with the initial values
				for (int i = 0; i < DIGEST_WORDS - 1; i++) begin
					chain_q[i] <= chain_q[i + 1];
				end
				chain_q[DIGEST_WORDS - 1] <= init_word(cmd.emit_idx);
			end
		end
	end

	assign st.fill_full   = (fill_q == BLOCK_END);
	assign st.fill_at_len = (fill_q == LEN_POS);
	assign digest         = digest_q;

endmodule
`default_nettype wire

// ----- hw/rtl/sha1md_ctrl.sv -----
`default_nettype none
module sha1md_ctrl
	import sha1md_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic       in_present,
	input  wire logic       in_last,
	output logic            in_ready,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [2:0]      out_index,
	output logic            out_last,
	input  wire status_t    st,
	output cmd_t            cmd
);

	typedef enum logic [2:0] {
		IDLE,
		PAD,
		ZERO,
		LEN,
		ROUND,
		UPDATE,
		EMIT
	} state_t;

	state_t     state_q, resume_q;
	logic [6:0] round_q;
	logic [2:0] len_cnt_q;
	logic [2:0] word_q;
	logic       out_valid_q;
	logic [2:0] out_index_q;
	logic       out_last_q;
	logic       accept;

	assign accept = in_valid && (state_q == IDLE);

	always_comb begin
		cmd           = '0;
		cmd.byte_sel  = BSEL_DATA;
		cmd.round_idx = round_q;
		cmd.emit_idx  = word_q;
		unique case (state_q)
			IDLE: begin
				cmd.shift_en  = accept && in_present;
				cmd.total_inc = accept && in_present;
			end
			PAD: begin
				cmd.shift_en = 1'b1;
				cmd.byte_sel = BSEL_PAD;
				cmd.len_load = 1'b1;
			end
			ZERO: begin
				cmd.shift_en = !st.fill_at_len;
				cmd.byte_sel = BSEL_ZERO;
			end
			LEN: begin
				cmd.shift_en = 1'b1;
				cmd.byte_sel = BSEL_LEN;
			end
			ROUND:  cmd.round_en = 1'b1;
			UPDATE: cmd.chain_add = 1'b1;
			EMIT:   cmd.emit_load = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			resume_q    <= IDLE;
			round_q     <= '0;
			len_cnt_q   <= '0;
			word_q      <= '0;
			out_valid_q <= 1'b0;
			out_index_q <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (cmd.emit_load) begin
				out_valid_q <= 1'b1;
				out_index_q <= word_q;
				out_last_q  <= (word_q == LAST_WORD_IDX);
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (accept) begin
						if (in_present && st.fill_full) begin
							state_q  <= ROUND;
							resume_q <= in_last ? PAD : IDLE;
						end else if (in_last) begin
							state_q <= PAD;
						end
					end
				end
				PAD: begin
					if (st.fill_full) begin
						state_q  <= ROUND;
						resume_q <= ZERO;
					end else begin
						state_q <= ZERO;
					end
				end
				ZERO: begin
					if (st.fill_at_len) begin
						state_q   <= LEN;
						len_cnt_q <= '0;
					end else if (st.fill_full) begin
						state_q  <= ROUND;
						resume_q <= ZERO;
					end
				end
				LEN: begin
					len_cnt_q <= len_cnt_q + 3'd1;
					if (len_cnt_q == LEN_LAST) begin
						state_q  <= ROUND;
						resume_q <= EMIT;
					end
				end
				ROUND: begin
					if (round_q == LAST_ROUND) begin
						round_q <= '0;
						state_q <= UPDATE;
					end else begin
						round_q <= round_q + 7'd1;
					end
				end
				UPDATE: begin
					state_q <= resume_q;
					word_q  <= '0;
				end
				EMIT: begin
					if (cmd.emit_load) begin
						word_q <= word_q + 3'd1;
						if (word_q == LAST_WORD_IDX) begin
							state_q <= IDLE;
						end
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == IDLE);
	assign out_valid = out_valid_q;
	assign out_index = out_index_q;
	assign out_last  = out_last_q;

`ifndef SYNTHESIS
	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ROUND) |-> (round_q <= LAST_ROUND))
		else $error("round counter past last round");

	a_len_fills_block: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == LEN && len_cnt_q == LEN_LAST) |-> st.fill_full)
		else $error("length field does not end the block");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_load |-> !(out_valid_q && !out_ready))
		else $error("digest word overwritten before taken");

	a_len_after_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == LEN && len_cnt_q == 3'd0) |-> st.fill_at_len)
		else $error("length field starts off position");
`endif

endmodule
`default_nettype wire

// ----- hw/rtl/sha1_message_digest.sv -----
`default_nettype none
// SHA-1 digest of a byte stream. Each input request carries one message byte
// (s_tuser set) and s_tlast closes the message; an empty message is one request
// with s_tuser clear and s_tlast set. Every 64th byte starts a compression
// (80 rounds, one per cycle, then the chaining add) during which input is held
// off. The closing request pads one byte per cycle up to the length field,
// running a compression whenever a block fills, then appends the 8 length
// bytes and runs the final compression; the five digest words then leave on
// the output side, most significant first, m_tuser giving the word index and
// m_tlast the fifth word.
// The next message can start while the last digest word still waits.
module sha1_message_digest
	import sha1md_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
	input  wire logic        s_tuser,   // [0] byte_present
	input  wire logic        s_tlast,   // is_last
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [31:0] m_tdata,   // [31:0] digest_word
	output logic      [2:0]  m_tuser,   // [2:0] word_index
	output logic             m_tlast    // last_word
);

	cmd_t    cmd;
	status_t st;

	sha1md_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_present (s_tuser),
		.in_last    (s_tlast),
		.in_ready   (s_tready),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_index  (m_tuser),
		.out_last   (m_tlast),
		.st         (st),
		.cmd        (cmd)
	);

	sha1md_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.data_byte (s_tdata),
		.st        (st),
		.digest    (m_tdata)
	);

endmodule
`default_nettype wire
